/* design/aadm_pkg.sv */
// Shared types and constants for the antenna angle decode and median unit.
`timescale 1ns / 1ps

package aadm_pkg;

	localparam int unsigned ANGLE_W = 16;
	localparam int unsigned PULSE_W = 16;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned NIB_W   = 4;

	// Binary angle scale: centideg = raw * 36000 >> 16
	localparam logic [15:0] BIN_SCALE = 16'd36000;

	// BCD digit weights in centidegrees
	localparam logic [15:0] W_HUNDREDS = 16'd10000;
	localparam logic [15:0] W_TENS     = 16'd1000;
	localparam logic [15:0] W_ONES     = 16'd100;
	localparam logic [15:0] W_TENTHS   = 16'd10;

	// Angle encoding register codes
	localparam logic FMT_BINARY = 1'b0;
	localparam logic FMT_BCD    = 1'b1;

	// Group counter saturation value
	localparam logic [1:0] GC_FULL = 2'd2;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [PULSE_W-1:0] pulse;
		logic [ANGLE_W-1:0] el;
		logic [ANGLE_W-1:0] az;
	} dec_item_t;

endpackage

/* design/aadm_decode.sv */
// Angle decoder: binary angle or BCD digits to centidegrees.
`timescale 1ns / 1ps

module aadm_decode (
	input  logic                          fmt,
	input  logic [aadm_pkg::BYTE_W-1:0]   hi,
	input  logic [aadm_pkg::BYTE_W-1:0]   lo,
	output logic [aadm_pkg::ANGLE_W-1:0]  centideg
);

	logic [31:0] bin_prod;
	logic [15:0] bcd_sum;

	assign bin_prod = {16'd0, hi, lo} * {16'd0, aadm_pkg::BIN_SCALE};

	assign bcd_sum = (16'(hi[5:4]) * aadm_pkg::W_HUNDREDS)
		+ (16'(hi[3:0]) * aadm_pkg::W_TENS)
		+ (16'(lo[7:4]) * aadm_pkg::W_ONES)
		+ (16'(lo[3:0]) * aadm_pkg::W_TENTHS);

	always_comb begin
		if (fmt == aadm_pkg::FMT_BCD) begin
			centideg = bcd_sum;
		end else begin
			centideg = bin_prod[31:16];
		end
	end

endmodule

/* design/aadm_filter.sv */
// Group-of-three sequencing, median select and result register.
`timescale 1ns / 1ps

module aadm_filter (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  aadm_pkg::dec_item_t   in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output aadm_pkg::dec_item_t   out_item
);

	aadm_pkg::phase_t phase_q, phase_nxt;
	logic [1:0]  gc_q;
	logic [15:0] az_a_q, az_b_q, el_a_q, el_b_q, pulse_a_q;
	logic        out_vld_q;
	aadm_pkg::dec_item_t out_item_q;

	logic out_free, take;
	logic cap_a, cap_b, emit;
	logic [15:0] med_az, med_el;

	function automatic logic [15:0] median3(input logic [15:0] a, input logic [15:0] b,
		input logic [15:0] c);
		logic [15:0] lo_ab, hi_ab, lo_hc;
		lo_ab = (a < b) ? a : b;
		hi_ab = (a < b) ? b : a;
		lo_hc = (hi_ab < c) ? hi_ab : c;
		return (lo_ab < lo_hc) ? lo_hc : lo_ab;
	endfunction

	assign out_free = !out_vld_q || out_ready;
	assign in_ready = (phase_q != aadm_pkg::PH_THIRD) || out_free;
	assign take     = in_valid && in_ready;

	assign med_az = median3(az_a_q, az_b_q, in_item.az);
	assign med_el = median3(el_a_q, el_b_q, in_item.el);

	always_comb begin
		case (phase_q)
			aadm_pkg::PH_FIRST:  phase_nxt = aadm_pkg::PH_SECOND;
			aadm_pkg::PH_SECOND: phase_nxt = aadm_pkg::PH_THIRD;
			aadm_pkg::PH_THIRD:  phase_nxt = aadm_pkg::PH_FIRST;
			default:             phase_nxt = aadm_pkg::PH_SECOND;
		endcase
	end

	always_comb begin
		cap_a = 1'b0;
		cap_b = 1'b0;
		emit  = 1'b0;
		case (phase_q)
			aadm_pkg::PH_FIRST:  cap_a = take;
			aadm_pkg::PH_SECOND: cap_b = take;
			aadm_pkg::PH_THIRD:  emit  = take;
			default:             cap_a = take;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= aadm_pkg::PH_FIRST;
			gc_q      <= 2'd0;
			out_vld_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_nxt;
			end
			if (emit && gc_q != aadm_pkg::GC_FULL) begin
				gc_q <= gc_q + 2'd1;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap_a) begin
			az_a_q    <= in_item.az;
			el_a_q    <= in_item.el;
			pulse_a_q <= in_item.pulse;
		end
		if (cap_b) begin
			az_b_q <= in_item.az;
			el_b_q <= in_item.el;
		end
		if (emit) begin
			out_item_q.pulse <= pulse_a_q;
			if (gc_q != aadm_pkg::GC_FULL) begin
				out_item_q.az <= in_item.az;
				out_item_q.el <= in_item.el;
			end else begin
				out_item_q.az <= med_az;
				out_item_q.el <= med_el;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_item  = out_item_q;

`ifndef SYNTHESIS
	a_emit_on_third: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(phase_q == aadm_pkg::PH_THIRD))
		else $error("result produced outside third reading");

	a_gc_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		gc_q != 2'd3)
		else $error("group counter passed saturation");

	a_warmup_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && gc_q != aadm_pkg::GC_FULL) |=>
		(out_item_q.az == $past(in_item.az) && out_item_q.el == $past(in_item.el)))
		else $error("warmup result not the third reading");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ready) |=> (out_vld_q && $stable(out_item_q)))
		else $error("stalled result changed");
`endif

endmodule

/* design/antenna_angle_decode_median_unit.sv */
// A group's third reading passes the input register and decoded-item register before its result is registered.
// Throughput: one reading per cycle; stalls only when a result waits at the output
// and the third reading of the next group arrives.
// Pipeline: input register, decode (one 16x16 multiply per axis), decoded-item register,
// median/result register.
// Reset: arst_n clears valid flags, read phase, group count and the format register.
`timescale 1ns / 1ps

module antenna_angle_decode_median_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,     // angle_format
	input  logic        s_tvalid,
	output logic        s_tready,
	// az_high_byte[7:0], az_low_byte[15:8], el_high_byte[23:16], el_low_byte[31:24],
	// count_nib_a[35:32], count_nib_b[39:36], count_nib_c[43:40], count_nib_d[47:44]
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// az_centideg[15:0], el_centideg[31:16], pulse_number[47:32]
	output logic [47:0] m_tdata
);

	logic        fmt_q;
	logic        vld_s1, vld_s2;
	logic        fmt_s1;
	logic [7:0]  az_hi_s1, az_lo_s1, el_hi_s1, el_lo_s1;
	logic [15:0] pulse_s1;
	aadm_pkg::dec_item_t item_s2, dec_item, out_item;

	logic f_ready, adv_s2, adv_s1;
	logic [15:0] az_dec, el_dec;

	assign adv_s2   = !vld_s2 || f_ready;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= aadm_pkg::FMT_BINARY;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				fmt_q <= cfg_wdata;
			end
			if (adv_s1) begin
				vld_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && adv_s1) begin
			fmt_s1   <= fmt_q;
			az_hi_s1 <= s_tdata[7:0];
			az_lo_s1 <= s_tdata[15:8];
			el_hi_s1 <= s_tdata[23:16];
			el_lo_s1 <= s_tdata[31:24];
			pulse_s1 <= {s_tdata[43:40], s_tdata[47:44], s_tdata[35:32], s_tdata[39:36]};
		end
		if (vld_s1 && adv_s2) begin
			item_s2 <= dec_item;
		end
	end

	aadm_decode u_dec_az (
		.fmt      (fmt_s1),
		.hi       (az_hi_s1),
		.lo       (az_lo_s1),
		.centideg (az_dec)
	);

	aadm_decode u_dec_el (
		.fmt      (fmt_s1),
		.hi       (el_hi_s1),
		.lo       (el_lo_s1),
		.centideg (el_dec)
	);

	always_comb begin
		dec_item.az    = az_dec;
		dec_item.el    = el_dec;
		dec_item.pulse = pulse_s1;
	end

	aadm_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_ready  (f_ready),
		.in_item   (item_s2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (out_item)
	);

	assign m_tdata = {out_item.pulse, out_item.el, out_item.az};

endmodule
